### src/tfps_pkg.sv
// shared types, codes and default sizes for the transmit frame packet segmenter
`default_nettype none

package tfps_pkg;

    // default sizes
    localparam int RING_SLOTS_DEF      = 8;
    localparam int MAX_FRAME_BYTES_DEF = 512;
    localparam int PACKET_BYTES_DEF    = 64;

    // fixed field widths
    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int OFFSET_W  = 9;
    localparam int LENGTH_W  = 7;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 32;

    localparam logic [TMO_W-1:0] BUSY_TIMEOUT_RESET = TMO_W'(100);

    // item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE       = 2'd0,
        MODE_DONE       = 2'd1,
        MODE_TICK       = 2'd2,
        MODE_LINK_RESET = 2'd3
    } mode_t;

    // frame write outcome
    typedef enum logic [STATUS_W-1:0] {
        WR_NONE     = 2'd0,
        WR_ACCEPTED = 2'd1,
        WR_TOO_LONG = 2'd2,
        WR_DROPPED  = 2'd3
    } wr_status_t;

endpackage

`default_nettype wire

### src/tfps_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/tx_frame_packet_segmenter.sv
// top level: usb bulk in transmit frame queue with packet segmentation and zlp
//
// input channel (in_valid/in_ready) carries one item per handshake: a frame
// byte, a transfer completion, a millisecond tick or a link reset, chosen by
// mode. each accepted item produces exactly one result item on the output
// channel (out_valid/out_ready): an optional packet descriptor (slot, offset,
// length), the frame write status, both event counters and the busy flag.
// an accepted item is held in the input register, worked in one
// combinational pass and then registered in the result register.
// throughput: one item per cycle while results are taken; the whole update
// is one pass from the input register to the result register, with the ring
// and frame length table updated on the same edge.
// when the receiver stalls the result register holds, the input register still
// takes one more item, and in_ready drops until the result is taken. busy_timeout_ms
// is written through cfg_wr_en/cfg_wr_data, by the user only while idle; unenforced.
// reset: ring empty, counters zero, timeout 100 ms, both registers empty.
// frame bytes land in the frame store ram (undefined until written); frame
// lengths live in a small per-slot table read at the ring head.
`default_nettype none

module tx_frame_packet_segmenter #(
    parameter int RING_SLOTS      = tfps_pkg::RING_SLOTS_DEF,
    parameter int MAX_FRAME_BYTES = tfps_pkg::MAX_FRAME_BYTES_DEF,
    parameter int PACKET_BYTES    = tfps_pkg::PACKET_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [tfps_pkg::TMO_W-1:0]      cfg_wr_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tfps_pkg::MODE_W-1:0]     mode,
    input  wire logic [tfps_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic                            frame_last,
    input  wire logic [tfps_pkg::TIME_W-1:0]     now_ms,
    input  wire logic                            endpoint_ready,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 send_valid,
    output logic [tfps_pkg::SLOT_OUT_W-1:0]      send_slot,
    output logic [tfps_pkg::OFFSET_W-1:0]        send_offset,
    output logic [tfps_pkg::LENGTH_W-1:0]        send_length,
    output logic [tfps_pkg::STATUS_W-1:0]        write_status,
    output logic [tfps_pkg::COUNT_W-1:0]         dropped_total,
    output logic [tfps_pkg::COUNT_W-1:0]         timeout_total,
    output logic                                 link_busy
);

    import tfps_pkg::*;

    localparam int SLOT_W  = $clog2(RING_SLOTS);
    localparam int LEN_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CHUNK_W = $clog2(PACKET_BYTES + 1);
    localparam int WIDE_W  = (LEN_W > CHUNK_W) ? LEN_W : CHUNK_W;
    localparam int DEPTH   = RING_SLOTS * MAX_FRAME_BYTES;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(RING_SLOTS - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN     = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0]  MAX_INDEX   = LEN_W'(MAX_FRAME_BYTES - 1);
    localparam logic [WIDE_W-1:0] PACKET_WIDE = WIDE_W'(PACKET_BYTES);
    localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(MAX_FRAME_BYTES);

    // input register
    logic              in_vld_reg, in_vld_next;
    mode_t             mode_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [TIME_W-1:0] now_reg;
    logic              ep_ready_reg;

    // result register
    logic                  out_vld_reg, out_vld_next;
    logic                  send_valid_reg, send_valid_next;
    logic [SLOT_OUT_W-1:0] send_slot_reg, send_slot_next;
    logic [OFFSET_W-1:0]   send_offset_reg, send_offset_next;
    logic [LENGTH_W-1:0]   send_length_reg, send_length_next;
    wr_status_t            status_reg, status_next;

    // queue state
    logic [TMO_W-1:0]   timeout_ms_reg;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               sent_all_reg, sent_all_next;   // pos equals head frame length
    logic               partial_reg, partial_next;     // a short packet was sent
    logic               zlp_reg, zlp_next;
    logic               busy_reg, busy_next;
    logic               armed_reg, armed_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]   gcount_reg, gcount_next;
    logic               gover_reg, gover_next;
    logic [COUNT_W-1:0] drop_reg, drop_next;
    logic [COUNT_W-1:0] tmo_cnt_reg, tmo_cnt_next;

    // per slot frame lengths, read at the head only
    logic [LEN_W-1:0] flen [RING_SLOTS];
    logic             flen_we;

    logic             advance;
    logic             store_we;
    logic [ADDR_W-1:0] store_waddr;
    logic [ADDR_W-1:0] store_raddr;
    logic [BYTE_W-1:0] store_rdata;

    logic [SLOT_W-1:0] tail_inc;
    logic [SLOT_W-1:0] head_inc;
    logic              try_send;
    logic [LEN_W-1:0]  head_len;
    logic [LEN_W-1:0]  remaining;
    logic [WIDE_W-1:0] chunk;
    logic [TIME_W-1:0] elapsed;
    logic [LEN_W-1:0]  read_index;

    // length of the frame closed by this byte
    function automatic logic [LEN_W-1:0] gcount_next_len(input logic [LEN_W-1:0] cnt);
        gcount_next_len = cnt + 1'b1;
    endfunction

    // handshake: the pass runs when the input register is full and the
    // result register is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign elapsed  = now_reg - start_reg;

    // one pass over the item
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        pos_next      = pos_reg;
        sent_all_next = sent_all_reg;
        partial_next  = partial_reg;
        zlp_next      = zlp_reg;
        busy_next     = busy_reg;
        armed_next    = armed_reg;
        start_next    = start_reg;
        gcount_next   = gcount_reg;
        gover_next    = gover_reg;
        drop_next     = drop_reg;
        tmo_cnt_next  = tmo_cnt_reg;
        status_next   = WR_NONE;
        flen_we       = 1'b0;
        store_we      = 1'b0;
        try_send      = 1'b0;

        unique case (mode_reg)
            MODE_BYTE:
            begin
                if (gcount_reg < MAX_LEN)
                begin
                    store_we    = 1'b1;
                    gcount_next = gcount_reg + 1'b1;
                end
                else
                begin
                    gover_next = 1'b1;
                end
                if (last_reg)
                begin
                    if (gover_next)
                    begin
                        status_next = WR_TOO_LONG;
                    end
                    else if (tail_inc == head_reg)
                    begin
                        status_next = WR_DROPPED;
                        drop_next   = drop_reg + 1'b1;
                    end
                    else
                    begin
                        flen_we     = 1'b1;
                        tail_next   = tail_inc;
                        status_next = WR_ACCEPTED;
                        try_send    = 1'b1;
                    end
                    gcount_next = '0;
                    gover_next  = 1'b0;
                end
            end
            MODE_DONE:
            begin
                busy_next = 1'b0;
                if (head_reg != tail_reg)
                begin
                    if (zlp_reg)
                    begin
                        zlp_next      = 1'b0;
                        head_next     = head_inc;
                        pos_next      = '0;
                        sent_all_next = 1'b0;
                        partial_next  = 1'b0;
                    end
                    else if (sent_all_reg)
                    begin
                        // a frame of whole packets owes a zero-length packet
                        if (!partial_reg)
                        begin
                            zlp_next = 1'b1;
                        end
                        else
                        begin
                            head_next     = head_inc;
                            pos_next      = '0;
                            sent_all_next = 1'b0;
                            partial_next  = 1'b0;
                        end
                    end
                    try_send = 1'b1;
                end
            end
            MODE_TICK:
            begin
                if (!busy_reg)
                begin
                    armed_next = 1'b0;
                end
                else if (!armed_reg)
                begin
                    armed_next = 1'b1;
                    start_next = now_reg;
                end
                else if (elapsed >= TIME_W'(timeout_ms_reg))
                begin
                    busy_next    = 1'b0;
                    armed_next   = 1'b0;
                    tmo_cnt_next = tmo_cnt_reg + 1'b1;
                    try_send     = 1'b1;
                end
            end
            MODE_LINK_RESET:
            begin
                head_next     = '0;
                tail_next     = '0;
                pos_next      = '0;
                sent_all_next = 1'b0;
                partial_next  = 1'b0;
                zlp_next      = 1'b0;
                busy_next     = 1'b0;
                armed_next    = 1'b0;
                start_next    = '0;
                gcount_next   = '0;
                gover_next    = 1'b0;
            end
        endcase

        // packet start from the (possibly advanced) head; a frame closed into
        // an empty ring is sent before its length reaches the table
        head_len = flen[head_next];
        if (flen_we && (head_next == tail_reg))
        begin
            head_len = gcount_next_len(gcount_reg);
        end
        remaining = (pos_next < head_len) ? head_len - pos_next : '0;
        chunk     = (WIDE_W'(remaining) < PACKET_WIDE) ? WIDE_W'(remaining) : PACKET_WIDE;

        send_valid_next  = 1'b0;
        send_slot_next   = '0;
        send_offset_next = '0;
        send_length_next = '0;
        if (try_send && !busy_next && (head_next != tail_next) && ep_ready_reg)
        begin
            busy_next        = 1'b1;
            send_valid_next  = 1'b1;
            send_slot_next   = SLOT_OUT_W'(head_next);
            send_offset_next = OFFSET_W'(pos_next);
            if (!zlp_next)
            begin
                send_length_next = LENGTH_W'(chunk);
                pos_next         = pos_next + LEN_W'(chunk);
                sent_all_next    = (WIDE_W'(remaining) == chunk);
                if ((remaining != '0) && (chunk != PACKET_WIDE))
                begin
                    partial_next = 1'b1;
                end
            end
        end
    end

    // frame store addressing
    assign read_index  = (pos_reg < MAX_LEN) ? pos_reg : MAX_INDEX;
    assign store_waddr = ADDR_W'(tail_reg) * SLOT_STRIDE + ADDR_W'(gcount_reg);
    assign store_raddr = ADDR_W'(head_reg) * SLOT_STRIDE + ADDR_W'(read_index);

    tfps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (advance && store_we),
        .wr_addr (store_waddr),
        .wr_data (byte_reg),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            timeout_ms_reg <= BUSY_TIMEOUT_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            pos_reg        <= '0;
            sent_all_reg   <= 1'b0;
            partial_reg    <= 1'b0;
            zlp_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            start_reg      <= '0;
            gcount_reg     <= '0;
            gover_reg      <= 1'b0;
            drop_reg       <= '0;
            tmo_cnt_reg    <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
            begin
                timeout_ms_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                pos_reg      <= pos_next;
                sent_all_reg <= sent_all_next;
                partial_reg  <= partial_next;
                zlp_reg      <= zlp_next;
                busy_reg     <= busy_next;
                armed_reg    <= armed_next;
                start_reg    <= start_next;
                gcount_reg   <= gcount_next;
                gover_reg    <= gover_next;
                drop_reg     <= drop_next;
                tmo_cnt_reg  <= tmo_cnt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg     <= mode_t'(mode);
            byte_reg     <= data_byte;
            last_reg     <= frame_last;
            now_reg      <= now_ms;
            ep_ready_reg <= endpoint_ready;
        end
        if (advance)
        begin
            send_valid_reg  <= send_valid_next;
            send_slot_reg   <= send_slot_next;
            send_offset_reg <= send_offset_next;
            send_length_reg <= send_length_next;
            status_reg      <= status_next;
        end
        if (advance && flen_we)
        begin
            flen[tail_reg] <= gcount_next_len(gcount_reg);
        end
    end

    assign out_valid     = out_vld_reg;
    assign send_valid    = send_valid_reg;
    assign send_slot     = send_slot_reg;
    assign send_offset   = send_offset_reg;
    assign send_length   = send_length_reg;
    assign write_status  = status_reg;
    assign dropped_total = drop_reg;
    assign timeout_total = tmo_cnt_reg;
    assign link_busy     = busy_reg;

endmodule

`default_nettype wire

### src/tfps_checker.sv
// port level checks for the transmit frame packet segmenter, bound to the top level
`default_nettype none

module tfps_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic                                send_valid,
    input wire logic [tfps_pkg::SLOT_OUT_W-1:0]     send_slot,
    input wire logic [tfps_pkg::OFFSET_W-1:0]       send_offset,
    input wire logic [tfps_pkg::LENGTH_W-1:0]       send_length,
    input wire logic [tfps_pkg::STATUS_W-1:0]       write_status,
    input wire logic [tfps_pkg::COUNT_W-1:0]        dropped_total,
    input wire logic                                link_busy
);

    import tfps_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(send_slot)
            && $stable(send_offset) && $stable(send_length) && $stable(write_status))
        else $error("result item changed while stalled");

    // a started packet leaves the link busy
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_valid |-> link_busy)
        else $error("packet started without busy");

    // no descriptor fields without a packet
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_valid |-> send_slot == '0 && send_offset == '0
            && send_length == '0)
        else $error("descriptor fields set without a packet");

    // a drop never comes with a packet start and leaves a nonzero drop count
    a_drop_nosend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_status == WR_DROPPED |-> !send_valid && dropped_total != '0)
        else $error("dropped frame with packet start or zero count");

endmodule

bind tx_frame_packet_segmenter tfps_checker u_tfps_checker (.*);

`default_nettype wire

### sim/tb_tx_frame_packet_segmenter.sv
// self-checking testbench for the usb bulk in transmit frame packet segmenter
`timescale 1ns / 1ps

module tb_tx_frame_packet_segmenter;
    import tfps_pkg::*;

    localparam int RING = RING_SLOTS_DEF;
    localparam int MAX_BYTES = MAX_FRAME_BYTES_DEF;
    localparam int PKT = PACKET_BYTES_DEF;

    // one result item as the block reports it
    typedef struct {
        logic                  send_valid;
        logic [SLOT_OUT_W-1:0] send_slot;
        logic [OFFSET_W-1:0]   send_offset;
        logic [LENGTH_W-1:0]   send_length;
        wr_status_t            write_status;
        logic [COUNT_W-1:0]    dropped_total;
        logic [COUNT_W-1:0]    timeout_total;
        logic                  link_busy;
    } seg_result_t;

    // clock, reset and block ports
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [TMO_W-1:0]      cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    mode_t                 mode = MODE_BYTE;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  frame_last = 1'b0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  endpoint_ready = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  send_valid;
    logic [SLOT_OUT_W-1:0] send_slot;
    logic [OFFSET_W-1:0]   send_offset;
    logic [LENGTH_W-1:0]   send_length;
    logic [STATUS_W-1:0]   write_status;
    logic [COUNT_W-1:0]    dropped_total;
    logic [COUNT_W-1:0]    timeout_total;
    logic                  link_busy;

    // predicted queue state
    logic [TMO_W-1:0]      q_timeout_ms;
    logic [9:0]            q_frame_len [RING];
    logic [SLOT_OUT_W-1:0] q_head;
    logic [SLOT_OUT_W-1:0] q_tail;
    logic [9:0]            q_pos;
    logic                  q_zlp;
    logic                  q_busy;
    logic                  q_armed;
    logic [TIME_W-1:0]     q_busy_since;
    logic [9:0]            q_gather;
    logic                  q_gather_over;
    logic [COUNT_W-1:0]    q_drops;
    logic [COUNT_W-1:0]    q_timeouts;

    seg_result_t pending_results [$];
    int          mismatches = 0;
    int          items_sent = 0;
    logic [TIME_W-1:0] sim_ms = '0;

    // idling controls
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold_left = 0;
    int rx_gap_left = 0;

    tx_frame_packet_segmenter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .data_byte      (data_byte),
        .frame_last     (frame_last),
        .now_ms         (now_ms),
        .endpoint_ready (endpoint_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .send_valid     (send_valid),
        .send_slot      (send_slot),
        .send_offset    (send_offset),
        .send_length    (send_length),
        .write_status   (write_status),
        .dropped_total  (dropped_total),
        .timeout_total  (timeout_total),
        .link_busy      (link_busy)
    );

    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] next_slot_of(logic [SLOT_OUT_W-1:0] s);
        return SLOT_OUT_W'((int'(s) + 1) % RING);
    endfunction

    task automatic clear_queue_state();
        q_timeout_ms = BUSY_TIMEOUT_RESET;
        for (int i = 0; i < RING; i++)
            q_frame_len[i] = '0;
        q_head = '0;
        q_tail = '0;
        q_pos = '0;
        q_zlp = 1'b0;
        q_busy = 1'b0;
        q_armed = 1'b0;
        q_busy_since = '0;
        q_gather = '0;
        q_gather_over = 1'b0;
        q_drops = '0;
        q_timeouts = '0;
    endtask

    // issue the next packet of the head frame when the endpoint can take it
    task automatic start_packet(input logic ready, inout seg_result_t r);
        int unsigned len;
        int unsigned remaining;
        int unsigned chunk;
        if (q_busy || q_head == q_tail || !ready)
            return;
        q_busy = 1'b1;
        r.send_valid = 1'b1;
        r.send_slot = q_head;
        r.send_offset = q_pos[OFFSET_W-1:0];
        if (q_zlp) begin
            r.send_length = '0;
            return;
        end
        len = q_frame_len[q_head];
        remaining = (q_pos < len) ? len - q_pos : 0;
        chunk = (remaining < PKT) ? remaining : PKT;
        r.send_length = LENGTH_W'(chunk);
        q_pos = q_pos + 10'(chunk);
    endtask

    // work out the result of one item and move the predicted state on
    task automatic segment_step(input mode_t m, input logic last, input logic [TIME_W-1:0] now,
                                input logic ready, output seg_result_t r);
        logic [TIME_W-1:0] elapsed;
        r.send_valid = 1'b0;
        r.send_slot = '0;
        r.send_offset = '0;
        r.send_length = '0;
        r.write_status = WR_NONE;
        case (m)
            MODE_BYTE: begin
                if (q_gather < MAX_BYTES)
                    q_gather = q_gather + 10'd1;
                else
                    q_gather_over = 1'b1;
                if (last) begin
                    if (q_gather_over) begin
                        r.write_status = WR_TOO_LONG;
                    end else if (next_slot_of(q_tail) == q_head) begin
                        r.write_status = WR_DROPPED;
                        q_drops = q_drops + 1;
                    end else begin
                        q_frame_len[q_tail] = q_gather;
                        q_tail = next_slot_of(q_tail);
                        r.write_status = WR_ACCEPTED;
                        start_packet(ready, r);
                    end
                    q_gather = '0;
                    q_gather_over = 1'b0;
                end
            end
            MODE_DONE: begin
                q_busy = 1'b0;
                if (q_head != q_tail) begin
                    if (q_zlp) begin
                        q_zlp = 1'b0;
                        q_head = next_slot_of(q_head);
                        q_pos = '0;
                    end else if (q_pos == q_frame_len[q_head]) begin
                        if (q_frame_len[q_head] % PKT == 0) begin
                            q_zlp = 1'b1;
                        end else begin
                            q_head = next_slot_of(q_head);
                            q_pos = '0;
                        end
                    end
                    start_packet(ready, r);
                end
            end
            MODE_TICK: begin
                elapsed = now - q_busy_since;
                if (!q_busy) begin
                    q_armed = 1'b0;
                end else if (!q_armed) begin
                    q_armed = 1'b1;
                    q_busy_since = now;
                end else if (elapsed >= {16'd0, q_timeout_ms}) begin
                    q_busy = 1'b0;
                    q_armed = 1'b0;
                    q_timeouts = q_timeouts + 1;
                    start_packet(ready, r);
                end
            end
            default: begin
                // link reset keeps the counters
                q_head = '0;
                q_tail = '0;
                q_pos = '0;
                q_zlp = 1'b0;
                q_busy = 1'b0;
                q_armed = 1'b0;
                q_busy_since = '0;
                q_gather = '0;
                q_gather_over = 1'b0;
            end
        endcase
        r.dropped_total = q_drops;
        r.timeout_total = q_timeouts;
        r.link_busy = q_busy;
    endtask

    // offer one item, hold it until accepted, then record what it should cause
    task automatic send_item(input mode_t m, input logic [BYTE_W-1:0] b, input logic last,
                             input logic [TIME_W-1:0] now, input logic ready);
        int gap;
        seg_result_t r;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= m;
        data_byte <= b;
        frame_last <= last;
        now_ms <= now;
        endpoint_ready <= ready;
        do
            @(posedge clk);
        while (!in_ready);
        segment_step(m, last, now, ready, r);
        pending_results.push_back(r);
        items_sent++;
    endtask

    // sender pauses until every result is back
    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_busy_timeout(input logic [TMO_W-1:0] value);
        wait_all_results();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        q_timeout_ms = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // completion, tick or link reset; completions favored while a packet is out
    task automatic send_random_event(input int ready_pct, input int done_pct);
        int r;
        int gate;
        logic ready;
        r = $urandom_range(0, 99);
        gate = q_busy ? done_pct : done_pct / 4;
        ready = ($urandom_range(0, 99) < ready_pct);
        if (r < 2) begin
            send_item(MODE_LINK_RESET, BYTE_W'($urandom), 1'($urandom), $urandom, ready);
        end else if (r < 2 + gate) begin
            send_item(MODE_DONE, BYTE_W'($urandom), 1'($urandom), $urandom, ready);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70)
                sim_ms = sim_ms + $urandom_range(0, 2 * int'(q_timeout_ms));
            else if (r < 90)
                sim_ms = sim_ms + $urandom_range(0, 3);
            else
                sim_ms = $urandom;
            send_item(MODE_TICK, BYTE_W'($urandom), 1'($urandom), sim_ms, ready);
        end
    endtask

    // one frame of random bytes, with other events slipped in between bytes
    task automatic send_frame(input int len, input int ready_pct, input int done_pct,
                              input int event_pct);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < event_pct)
                send_random_event(ready_pct, done_pct);
            send_item(MODE_BYTE, BYTE_W'($urandom), (i == len - 1),
                      $urandom, ($urandom_range(0, 99) < ready_pct));
        end
    endtask

    // compares one field and logs a mismatch
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // receiver: long hold-off first, then random gaps when enabled
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_gap_left > 0) begin
            out_ready <= 1'b0;
            rx_gap_left--;
        end else begin
            out_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0)
                rx_gap_left = pick_gap();
        end
    end

    // result checker: each accepted result against the oldest expectation
    always @(posedge clk) begin
        seg_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no pending expectation");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("send_valid", want.send_valid, send_valid);
                check_field("send_slot", want.send_slot, send_slot);
                check_field("send_offset", want.send_offset, send_offset);
                check_field("send_length", want.send_length, send_length);
                check_field("write_status", want.write_status, write_status);
                check_field("dropped_total", want.dropped_total, dropped_total);
                check_field("timeout_total", want.timeout_total, timeout_total);
                check_field("link_busy", want.link_busy, link_busy);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // two-byte frame goes out at once, completion frees the slot
    task automatic test_single_packet();
        send_item(MODE_BYTE, 8'h00, 1'b0, 32'h0, 1'b1);
        send_item(MODE_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_DONE, 8'h00, 1'b0, 32'h0, 1'b1);
    endtask

    // endpoint not ready holds the frame back until a later completion
    task automatic test_endpoint_not_ready();
        send_item(MODE_BYTE, 8'h5A, 1'b1, 32'h0, 1'b0);
        send_item(MODE_DONE, 8'h00, 1'b0, 32'h0, 1'b0);
        send_item(MODE_DONE, 8'h00, 1'b0, 32'h0, 1'b1);
        send_item(MODE_DONE, 8'h00, 1'b0, 32'h0, 1'b1);
    endtask

    // completion with nothing queued only clears busy
    task automatic test_empty_ring_done();
        send_item(MODE_DONE, 8'hA5, 1'b1, 32'h0, 1'b1);
    endtask

    // one slot stays empty: seven frames fit, the eighth is dropped
    task automatic test_ring_full();
        for (int i = 0; i < RING; i++)
            send_item(MODE_BYTE, BYTE_W'($urandom), 1'b1, 32'h0, 1'b0);
        send_item(MODE_LINK_RESET, 8'h00, 1'b0, 32'h0, 1'b0);
    endtask

    // release across the time wrap, resend from an offset at the frame end
    task automatic test_busy_timeout();
        set_busy_timeout(16'd1);
        send_item(MODE_BYTE, 8'h81, 1'b1, 32'h0, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0, 32'h0000_0000, 1'b1);
        send_item(MODE_DONE, 8'h00, 1'b0, 32'h0, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0, 32'h0000_0005, 1'b1);
    endtask

    // link reset drops a partly gathered frame
    task automatic test_link_reset_mid_frame();
        send_item(MODE_BYTE, 8'h11, 1'b0, 32'h0, 1'b1);
        send_item(MODE_BYTE, 8'h22, 1'b0, 32'h0, 1'b1);
        send_item(MODE_LINK_RESET, 8'h00, 1'b0, 32'h0, 1'b1);
    endtask

    // packet boundaries, zlp, the largest frame and frames that are too long
    task automatic test_frame_sizes();
        int sizes [5] = '{PKT, 2 * PKT, MAX_BYTES, MAX_BYTES + 1, MAX_BYTES + 8};
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (sizes[k]) begin
            send_frame(sizes[k], 100, 0, 0);
            while (q_head != q_tail)
                send_item(MODE_DONE, BYTE_W'($urandom), 1'($urandom), $urandom, 1'b1);
        end
    endtask

    // well-formed frames of random size mixed with completions, ticks and resets
    task automatic test_random_traffic(input int n_items, input int ready_pct,
                                       input int done_pct);
        int stop_at;
        int r;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 45) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    len = $urandom_range(1, 6);
                else if (r < 75)
                    len = $urandom_range(7, 40);
                else if (r < 90)
                    len = $urandom_range(PKT - 2, PKT + 2);
                else
                    len = $urandom_range(2 * PKT - 2, 2 * PKT + 2);
                send_frame(len, ready_pct, done_pct, 6);
            end else begin
                send_random_event(ready_pct, done_pct);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        wait_all_results();
        tx_idle_on = 1'b0;
        rx_hold_left = 80;
        test_random_traffic(40, 80, 60);
        wait_all_results();
    endtask

    initial begin
        clear_queue_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, at the reset timeout until the busy timeout test sets it to 1
        test_single_packet();
        test_endpoint_not_ready();
        test_empty_ring_done();
        test_ring_full();
        test_busy_timeout();
        test_link_reset_mid_frame();

        test_frame_sizes();

        // random part over several timeout settings
        set_busy_timeout(16'hFFFF);
        test_random_traffic(150, 85, 70);
        set_busy_timeout(16'($urandom_range(1, 50)));
        test_random_traffic(150, 40, 25);
        set_busy_timeout(16'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(120, 90, 60);
        set_busy_timeout(BUSY_TIMEOUT_RESET);
        rx_idle_on = 1'b1;
        test_backpressure();

        wait_all_results();
        if (mismatches == 0)
            $display("[tx_frame_packet_segmenter] OK");
        else
            $display("[tx_frame_packet_segmenter] ERROR");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("[tx_frame_packet_segmenter] ERROR");
        $finish;
    end

endmodule
